// File: design/rhp_pkg.sv
`timescale 1ns / 1ps
package rhp_pkg;

  localparam int INPUT_W        = 16;
  localparam int CHANNEL_BITS_D = 16;
  localparam int HUE_W          = 9;
  localparam int PCT_W          = 7;

  // quotient bits per division chain
  localparam int DIV_Q    = 7;
  // hue / saturation division: remainder and divisor widths
  localparam int HS_W     = 14;
  localparam int HS_DW    = 8;

  localparam int PCT_SCALE = 100;
  localparam int HUE_STEP  = 60;
  localparam int HUE_FULL  = 360;
  localparam int HUE_GREEN = 120;
  localparam int HUE_BLUE  = 240;
  localparam int SUM_FULL  = 200;
  localparam int L_HALF    = 50;

  typedef struct packed {
    logic       zero;
    logic [2:0] ovf;
  } pct_side_t;

  typedef struct packed {
    logic              zero;
    logic              gray;
    logic              neg;
    logic [HUE_W-1:0]  base;
    logic [PCT_W-1:0]  light;
  } hs_side_t;

endpackage

// File: design/rhp_in_if.sv
`timescale 1ns / 1ps
interface rhp_in_if;
  import rhp_pkg::*;
  logic               valid;
  logic               ready;
  logic [INPUT_W-1:0] clear_count;
  logic [INPUT_W-1:0] red_count;
  logic [INPUT_W-1:0] green_count;
  logic [INPUT_W-1:0] blue_count;
  modport source (output valid, clear_count, red_count, green_count, blue_count,
                  input ready);
  modport sink (input valid, clear_count, red_count, green_count, blue_count,
                output ready);
endinterface

// File: design/rhp_out_if.sv
`timescale 1ns / 1ps
interface rhp_out_if;
  import rhp_pkg::*;
  logic             valid;
  logic             ready;
  logic [HUE_W-1:0] hue;
  logic [PCT_W-1:0] saturation;
  logic [PCT_W-1:0] lightness;
  logic             zero_clear;
  modport source (output valid, hue, saturation, lightness, zero_clear, input ready);
  modport sink (input valid, hue, saturation, lightness, zero_clear, output ready);
endinterface

// File: design/rgbc_to_hsl_percent_core.sv
`timescale 1ns / 1ps
// Clear/red/green/blue counts to hue (0..360), saturation and lightness (0..100).
// Fully pipelined: one transaction is accepted every cycle while the output
// is not stalled. The pipe holds two rows of restoring-division cells, each
// cell settling one quotient bit: the first row scales the three colors to
// percent of clear, the second computes the hue fraction and saturation
// side by side. A stall on the output freezes the whole pipe. Percents
// saturate at 100; a zero clear count yields zeros with zero_clear set.
module rgbc_to_hsl_percent_core #(
  parameter int CHANNEL_BITS = rhp_pkg::CHANNEL_BITS_D
) (
  input  logic      clk,
  input  logic      rst,
  rhp_in_if.sink    in_ch,
  rhp_out_if.source out_ch
);
  import rhp_pkg::*;

  localparam int NW = CHANNEL_BITS + 7;  // count * 100

  logic en;

  // ---------------- stage 0: scale numerators, overflow check
  logic [CHANNEL_BITS-1:0]          clr;
  logic [2:0][CHANNEL_BITS-1:0]     cnt;
  logic [2:0][NW-1:0]               num;
  logic [2:0]                       ovf;

  logic                             s0_valid;
  logic [2:0][NW-1:0]               s0_num;
  logic [2:0][CHANNEL_BITS-1:0]     s0_den;
  pct_side_t                        s0_side;

  assign clr    = in_ch.clear_count[CHANNEL_BITS-1:0];
  assign cnt[0] = in_ch.red_count[CHANNEL_BITS-1:0];
  assign cnt[1] = in_ch.green_count[CHANNEL_BITS-1:0];
  assign cnt[2] = in_ch.blue_count[CHANNEL_BITS-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = NW'(cnt[i]) * NW'(PCT_SCALE);
      // quotient would not fit in DIV_Q bits: saturate later
      ovf[i] = num[i][NW-1:DIV_Q] >= clr;
    end
  end

  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_num       <= num;
      s0_den       <= {3{clr}};
      s0_side.zero <= (clr == '0);
      s0_side.ovf  <= ovf;
    end
  end

  // ---------------- percent division row
  logic                      p_valid;
  logic [2:0][DIV_Q-1:0]     p_q;
  logic [$bits(pct_side_t)-1:0] p_side_raw;
  pct_side_t                 p_side;

  rhp_div_chain #(
    .W(NW), .DW(CHANNEL_BITS), .Q(DIV_Q), .LANES(3), .PW($bits(pct_side_t))
  ) u_pct (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s0_valid), .in_num(s0_num), .in_den(s0_den), .in_side(s0_side),
    .out_valid(p_valid), .out_q(p_q), .out_side(p_side_raw)
  );

  assign p_side = pct_side_t'(p_side_raw);

  // ---------------- stage M: max/min, sector, lightness, divisor setup
  logic [2:0][PCT_W-1:0] pct;
  logic [PCT_W-1:0]      mx, mn, ha, hb, hdiff;
  logic [PCT_W-1:0]      dif;
  logic [PCT_W:0]        sum;
  logic [PCT_W-1:0]      light;
  logic [HUE_W-1:0]      base;
  logic                  neg;
  logic [HS_DW-1:0]      sden;
  logic [HS_DW-1:0]      hden;

  logic                          m_valid;
  logic [1:0][HS_W-1:0]          m_num;
  logic [1:0][HS_DW-1:0]         m_den;
  hs_side_t                      m_side;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (p_side.ovf[i] || p_q[i] > DIV_Q'(PCT_SCALE)) begin
        pct[i] = PCT_W'(PCT_SCALE);
      end else begin
        pct[i] = p_q[i];
      end
    end
    // ties resolve red, then green, then blue
    priority if (pct[0] >= pct[1] && pct[0] >= pct[2]) begin
      mx = pct[0]; ha = pct[1]; hb = pct[2]; base = '0;
    end else if (pct[1] >= pct[2]) begin
      mx = pct[1]; ha = pct[2]; hb = pct[0]; base = HUE_W'(HUE_GREEN);
    end else begin
      mx = pct[2]; ha = pct[0]; hb = pct[1]; base = HUE_W'(HUE_BLUE);
    end
    mn = pct[0];
    if (pct[1] < mn) mn = pct[1];
    if (pct[2] < mn) mn = pct[2];
    dif   = mx - mn;
    sum   = {1'b0, mx} + {1'b0, mn};
    light = sum[PCT_W:1];
    neg   = ha < hb;
    hdiff = neg ? hb - ha : ha - hb;
    // red sector going negative wraps from the top of the circle
    if (neg && base == '0) begin
      base = HUE_W'(HUE_FULL);
    end
    if (light <= PCT_W'(L_HALF)) begin
      sden = sum;
    end else begin
      sden = HS_DW'(SUM_FULL) - sum;
    end
    hden = (dif == '0) ? HS_DW'(1) : {1'b0, dif};
    if (sden == '0) begin
      sden = HS_DW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_num[0]     <= HS_W'(hdiff) * HS_W'(HUE_STEP);
      m_num[1]     <= HS_W'(dif) * HS_W'(PCT_SCALE);
      m_den[0]     <= hden;
      m_den[1]     <= sden;
      m_side.zero  <= p_side.zero;
      m_side.gray  <= (dif == '0);
      m_side.neg   <= neg;
      m_side.base  <= base;
      m_side.light <= light;
    end
  end

  // ---------------- hue / saturation division row
  logic                         h_valid;
  logic [1:0][DIV_Q-1:0]        h_q;
  logic [$bits(hs_side_t)-1:0]  h_side_raw;
  hs_side_t                     h_side;

  rhp_div_chain #(
    .W(HS_W), .DW(HS_DW), .Q(DIV_Q), .LANES(2), .PW($bits(hs_side_t))
  ) u_hs (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(m_valid), .in_num(m_num), .in_den(m_den), .in_side(m_side),
    .out_valid(h_valid), .out_q(h_q), .out_side(h_side_raw)
  );

  assign h_side = hs_side_t'(h_side_raw);

  // ---------------- output register
  logic [HUE_W-1:0] hue_next;
  logic [PCT_W-1:0] sat_next;
  logic [PCT_W-1:0] light_next;

  always_comb begin
    if (h_side.zero || h_side.gray) begin
      hue_next = '0;
      sat_next = '0;
    end else begin
      hue_next = h_side.neg ? h_side.base - HUE_W'(h_q[0])
                            : h_side.base + HUE_W'(h_q[0]);
      sat_next = h_q[1];
    end
    light_next = h_side.zero ? '0 : h_side.light;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (en) begin
      out_ch.valid <= h_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.hue        <= hue_next;
      out_ch.saturation <= sat_next;
      out_ch.lightness  <= light_next;
      out_ch.zero_clear <= h_side.zero;
    end
  end

endmodule

// File: design/rhp_div_cell.sv
`timescale 1ns / 1ps
// One restoring division step per lane: settle quotient bit K.
module rhp_div_cell #(
  parameter int W     = 14,
  parameter int DW    = 8,
  parameter int Q     = 7,
  parameter int K     = 0,
  parameter int LANES = 1,
  parameter int PW    = 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [LANES-1:0][W-1:0]        in_rem,
  input  logic [LANES-1:0][DW-1:0]       in_den,
  input  logic [LANES-1:0][Q-1:0]        in_q,
  input  logic [PW-1:0]                  in_side,
  output logic                           out_valid,
  output logic [LANES-1:0][W-1:0]        out_rem,
  output logic [LANES-1:0][DW-1:0]       out_den,
  output logic [LANES-1:0][Q-1:0]        out_q,
  output logic [PW-1:0]                  out_side
);

  logic [LANES-1:0][W-1:0] rem_next;
  logic [LANES-1:0][Q-1:0] q_next;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      logic [W-1:0] trial;
      trial = W'(in_den[i]) << K;
      rem_next[i] = in_rem[i];
      q_next[i]   = in_q[i];
      if (in_rem[i] >= trial) begin
        rem_next[i] = in_rem[i] - trial;
        q_next[i][K] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= rem_next;
      out_den  <= in_den;
      out_q    <= q_next;
      out_side <= in_side;
    end
  end

endmodule

// File: design/rhp_div_chain.sv
`timescale 1ns / 1ps
// Row of division cells, most significant quotient bit first.
module rhp_div_chain #(
  parameter int W     = 14,
  parameter int DW    = 8,
  parameter int Q     = 7,
  parameter int LANES = 1,
  parameter int PW    = 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [LANES-1:0][W-1:0]  in_num,
  input  logic [LANES-1:0][DW-1:0] in_den,
  input  logic [PW-1:0]            in_side,
  output logic                     out_valid,
  output logic [LANES-1:0][Q-1:0]  out_q,
  output logic [PW-1:0]            out_side
);

  logic [Q:0]                      v_s;
  logic [Q:0][LANES-1:0][W-1:0]    rem_s;
  logic [Q:0][LANES-1:0][DW-1:0]   den_s;
  logic [Q:0][LANES-1:0][Q-1:0]    q_s;
  logic [Q:0][PW-1:0]              side_s;

  assign v_s[0]    = in_valid;
  assign rem_s[0]  = in_num;
  assign den_s[0]  = in_den;
  assign q_s[0]    = '0;
  assign side_s[0] = in_side;

  for (genvar s = 0; s < Q; s++) begin : g_cell
    rhp_div_cell #(
      .W(W), .DW(DW), .Q(Q), .K(Q - 1 - s), .LANES(LANES), .PW(PW)
    ) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(v_s[s]), .in_rem(rem_s[s]), .in_den(den_s[s]),
      .in_q(q_s[s]), .in_side(side_s[s]),
      .out_valid(v_s[s+1]), .out_rem(rem_s[s+1]), .out_den(den_s[s+1]),
      .out_q(q_s[s+1]), .out_side(side_s[s+1])
    );
  end

  assign out_valid = v_s[Q];
  assign out_q     = q_s[Q];
  assign out_side  = side_s[Q];

endmodule

// File: tb/rhp_tb_if.sv
`timescale 1ns / 1ps
// The block's channel interfaces live in the design folder; this file only
// keeps the testbench side in step with the project layout.
package rhp_tb_pkg;
  import rhp_pkg::*;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] saturation;
    logic [PCT_W-1:0] lightness;
    logic             zero_clear;
  } hsl_t;
endpackage

// File: tb/rhp_checker.sv
`timescale 1ns / 1ps
module rhp_checker #(
  parameter int CHANNEL_BITS = rhp_pkg::CHANNEL_BITS_D
) (
  input  logic clk,
  input  logic rst,
  rhp_in_if    in_ch,
  rhp_out_if   out_ch,
  output int   fail_count,
  output int   pending
);
  import rhp_pkg::*;
  import rhp_tb_pkg::*;

  hsl_t hsl_queue[$];

  function automatic int unsigned pct_of_clear(int unsigned cnt, int unsigned clr);
    int unsigned p;
    p = (cnt * 100) / clr;
    return (p > 100) ? 100 : p;
  endfunction

  function automatic hsl_t convert_hsl(logic [15:0] c_in, logic [15:0] r_in,
                                       logic [15:0] g_in, logic [15:0] b_in);
    hsl_t res;
    int unsigned msk, c, r, g, b, mx, mn, dif, sum, l, h, s, den;
    msk = (1 << CHANNEL_BITS) - 1;
    c = c_in & msk;
    res = '0;
    if (c == 0) begin
      res.zero_clear = 1'b1;
      return res;
    end
    r = pct_of_clear(r_in & msk, c);
    g = pct_of_clear(g_in & msk, c);
    b = pct_of_clear(b_in & msk, c);
    mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
    mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
    dif = mx - mn;
    sum = mx + mn;
    l = sum / 2;
    h = 0;
    s = 0;
    if (dif != 0) begin
      if (mx == r) h = (g >= b) ? (60 * (g - b)) / dif : 360 - (60 * (b - g)) / dif;
      else if (mx == g) h = (b >= r) ? 120 + (60 * (b - r)) / dif : 120 - (60 * (r - b)) / dif;
      else h = (r >= g) ? 240 + (60 * (r - g)) / dif : 240 - (60 * (g - r)) / dif;
      if (l <= 50) s = (dif * 100) / sum;
      else begin
        den = 200 - sum;
        s = (den != 0) ? (dif * 100) / den : 100;
      end
      if (s > 100) s = 100;
    end
    res.hue = h[HUE_W-1:0];
    res.saturation = s[PCT_W-1:0];
    res.lightness = l[PCT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  assign pending = hsl_queue.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    hsl_t want;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready)
        hsl_queue.push_back(convert_hsl(in_ch.clear_count, in_ch.red_count,
                                        in_ch.green_count, in_ch.blue_count));
      if (out_ch.valid && out_ch.ready) begin
        if (hsl_queue.size() == 0) report_mismatch("unexpected result", 1, 0);
        else begin
          want = hsl_queue.pop_front();
          if (out_ch.hue !== want.hue) report_mismatch("hue", out_ch.hue, want.hue);
          if (out_ch.saturation !== want.saturation)
            report_mismatch("saturation", out_ch.saturation, want.saturation);
          if (out_ch.lightness !== want.lightness)
            report_mismatch("lightness", out_ch.lightness, want.lightness);
          if (out_ch.zero_clear !== want.zero_clear)
            report_mismatch("zero_clear", out_ch.zero_clear, want.zero_clear);
        end
      end
    end
  end
endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import rhp_pkg::*;

  localparam int LATENCY = 2 * DIV_Q + 3;
  localparam int RANDOM_ITEMS = 1500;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;

  rhp_in_if  in_ch();
  rhp_out_if out_ch();

  rgbc_to_hsl_percent_core u_top (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  rhp_checker u_chk (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: stall on its own pattern, long runs of always-ready mixed in.
  int stall_mode = 0;
  int stall_left = 0;
  initial out_ch.ready = 1'b0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(5, 60);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      2: out_ch.ready <= ($urandom_range(0, 1) != 0);
      default: out_ch.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.clear_count = '0;
    in_ch.red_count = '0;
    in_ch.green_count = '0;
    in_ch.blue_count = '0;
  end

  // Hold the item until the handshake completes; valid stays high across
  // back-to-back transactions so it is never dropped and raised in one step.
  task automatic send_reading(logic [15:0] c, logic [15:0] r, logic [15:0] g,
                              logic [15:0] b);
    in_ch.valid <= 1'b1;
    in_ch.clear_count <= c;
    in_ch.red_count <= r;
    in_ch.green_count <= g;
    in_ch.blue_count <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Random reading: most use a clear count near the colors so percents land
  // in range; some draw raw full-width values to hit saturation and wide bits.
  task automatic send_random();
    logic [15:0] c, r, g, b;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      c = 16'($urandom_range(1, 65535));
      r = 16'($urandom_range(0, c));
      g = 16'($urandom_range(0, c));
      b = 16'($urandom_range(0, c));
    end else if (sel < 8) begin
      c = 16'($urandom_range(1, 200));
      r = 16'($urandom_range(0, 200));
      g = 16'($urandom_range(0, 200));
      b = 16'($urandom_range(0, 200));
    end else if (sel == 8) begin
      c = 16'($urandom_range(0, 3));
      r = 16'($urandom); g = 16'($urandom); b = 16'($urandom);
    end else begin
      c = 16'($urandom); r = 16'($urandom); g = 16'($urandom); b = 16'($urandom);
    end
    send_reading(c, r, g, b);
  endtask

  initial begin
    int burst;
    int waited;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero clear, extremes, gray, tie orders, each sector, and
    // the red sector with green below blue that can reach 360.
    send_reading(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_reading(16'd0, 16'd0, 16'd0, 16'd0);
    send_reading(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_reading(16'hFFFF, 16'd0, 16'd0, 16'd0);
    send_reading(16'd1, 16'hFFFF, 16'd0, 16'd0);
    send_reading(16'd100, 16'd50, 16'd50, 16'd50);
    send_reading(16'd100, 16'd100, 16'd100, 16'd0);
    send_reading(16'd100, 16'd0, 16'd100, 16'd100);
    send_reading(16'd100, 16'd100, 16'd0, 16'd100);
    send_reading(16'd100, 16'd100, 16'd30, 16'd10);
    send_reading(16'd100, 16'd100, 16'd10, 16'd30);
    send_reading(16'd100, 16'd100, 16'd0, 16'd1);
    send_reading(16'd100, 16'd20, 16'd90, 16'd40);
    send_reading(16'd100, 16'd40, 16'd90, 16'd20);
    send_reading(16'd100, 16'd20, 16'd40, 16'd90);
    send_reading(16'd100, 16'd40, 16'd20, 16'd90);
    send_reading(16'd100, 16'd100, 16'd99, 16'd99);
    send_reading(16'd100, 16'd1, 16'd0, 16'd0);
    send_reading(16'd3, 16'd2, 16'd1, 16'd0);
    send_reading(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    send_reading(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);

    // Random bursts with random gaps
    for (int i = 0; i < RANDOM_ITEMS; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && i < RANDOM_ITEMS; k++, i++) send_random();
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
    end
    idle_gap(1);

    waited = 0;
    while (pending != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY * 4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS rgbc_to_hsl_percent_core");
    end else begin
      $display("FAIL rgbc_to_hsl_percent_core");
    end
    $finish;
  end

  // Watchdog: far past the slowest correct run.
  initial begin
    #20ms;
    $display("FAIL rgbc_to_hsl_percent_core");
    $finish;
  end
endmodule
